[rtl/ppf_pkg.sv]
// Package for the preference function unit: shape codes, result select codes,
// shared structs and the exponential tables of the gaussian shape.
// No dependencies.
package ppf_pkg;

    localparam int DATA_W  = 32;            // Q16.16 width of d, q and p
    localparam int SIGMA_W = 31;            // width of the gaussian spread
    localparam int PREF_W  = 17;            // Q0.16 result width
    localparam int QUO_W   = 19;            // quotient bits, below 5.0 in Q.16
    localparam int REM_W   = DATA_W + 1;    // divider partial remainder
    localparam int E_W     = 25;            // Q0.24 values up to 1.0 inclusive
    localparam int CFG_IDX_W = 2;

    localparam logic [PREF_W-1:0] PREF_ONE  = 17'd65536;
    localparam logic [PREF_W-1:0] PREF_HALF = 17'd32768;
    localparam logic [PREF_W-1:0] PREF_ZERO = 17'd0;
    localparam logic [49:0]       RND_Q24   = 50'd8388608;
    localparam logic [E_W-1:0]    ONE_Q24   = 25'd16777216;

    typedef enum logic [2:0] {
        SHAPE_USUAL  = 3'd0,
        SHAPE_U      = 3'd1,
        SHAPE_V      = 3'd2,
        SHAPE_LEVEL  = 3'd3,
        SHAPE_V_IND  = 3'd4,
        SHAPE_GAUSS  = 3'd5
    } t_shape;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE = 2'd0,
        REG_Q     = 2'd1,
        REG_P     = 2'd2,
        REG_SIGMA = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_FIXED = 2'd0,
        SEL_RAMP  = 2'd1,
        SEL_GAUSS = 2'd2
    } t_res_sel;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0]         shape;
        logic [DATA_W-1:0]  q;
        logic [DATA_W-1:0]  p;
        logic [SIGMA_W-1:0] sigma;
    } t_cfg;

    // Per-item control that travels beside the arithmetic.
    typedef struct packed {
        t_res_sel          sel;
        logic [PREF_W-1:0] fixed;
    } t_side;

    // exp(-n), n = 0..12, Q0.24
    function automatic logic [E_W-1:0] en_lut(input logic [3:0] n);
        logic [E_W-1:0] v;
        unique case (n)
            4'd0:  v = 25'd16777216;
            4'd1:  v = 25'd6171993;
            4'd2:  v = 25'd2270549;
            4'd3:  v = 25'd835288;
            4'd4:  v = 25'd307285;
            4'd5:  v = 25'd113044;
            4'd6:  v = 25'd41587;
            4'd7:  v = 25'd15299;
            4'd8:  v = 25'd5628;
            4'd9:  v = 25'd2070;
            4'd10: v = 25'd762;
            4'd11: v = 25'd280;
            default: v = 25'd103;
        endcase
        return v;
    endfunction

    // exp(-a/16), a = 0..15, Q0.24
    function automatic logic [E_W-1:0] ea_lut(input logic [3:0] a);
        logic [E_W-1:0] v;
        unique case (a)
            4'd0:  v = 25'd16777216;
            4'd1:  v = 25'd15760736;
            4'd2:  v = 25'd14805841;
            4'd3:  v = 25'd13908801;
            4'd4:  v = 25'd13066109;
            4'd5:  v = 25'd12274473;
            4'd6:  v = 25'd11530801;
            4'd7:  v = 25'd10832185;
            4'd8:  v = 25'd10175896;
            4'd9:  v = 25'd9559370;
            4'd10: v = 25'd8980197;
            4'd11: v = 25'd8436114;
            4'd12: v = 25'd7924996;
            4'd13: v = 25'd7444844;
            4'd14: v = 25'd6993784;
            default: v = 25'd6570052;
        endcase
        return v;
    endfunction

    // exp(-b/256), b = 0..15, Q0.24
    function automatic logic [E_W-1:0] eb_lut(input logic [3:0] b);
        logic [E_W-1:0] v;
        unique case (b)
            4'd0:  v = 25'd16777216;
            4'd1:  v = 25'd16711808;
            4'd2:  v = 25'd16646655;
            4'd3:  v = 25'd16581756;
            4'd4:  v = 25'd16517109;
            4'd5:  v = 25'd16452715;
            4'd6:  v = 25'd16388572;
            4'd7:  v = 25'd16324679;
            4'd8:  v = 25'd16261035;
            4'd9:  v = 25'd16197640;
            4'd10: v = 25'd16134491;
            4'd11: v = 25'd16071589;
            4'd12: v = 25'd16008931;
            4'd13: v = 25'd15946518;
            4'd14: v = 25'd15884349;
            default: v = 25'd15822422;
        endcase
        return v;
    endfunction

endpackage

[rtl/ppf_front.sv]
// Front stage: threshold compares, shape decode and divider operand setup.
// Depends on ppf_pkg.
module ppf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ppf_pkg::DATA_W-1:0]  i_d,
    input  ppf_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    output logic [ppf_pkg::DATA_W-1:0]  o_num,
    output logic [ppf_pkg::DATA_W-1:0]  o_den,
    output ppf_pkg::t_side              o_side
);

    logic                       r_valid;
    logic [ppf_pkg::DATA_W-1:0] r_num, n_num;
    logic [ppf_pkg::DATA_W-1:0] r_den, n_den;
    ppf_pkg::t_side             r_side, n_side;

    logic              le_zero, le_q, le_p, ge_5s;
    logic [ppf_pkg::DATA_W:0]   d_minus_q, p_minus_q;
    logic [ppf_pkg::DATA_W+1:0] sigma5;

    always_comb begin
        le_zero   = $signed(i_d) <= 0;
        le_q      = $signed(i_d) <= $signed(i_cfg.q);
        le_p      = $signed(i_d) <= $signed(i_cfg.p);
        sigma5    = {3'b000, i_cfg.sigma} + {1'b0, i_cfg.sigma, 2'b00};
        ge_5s     = {2'b00, i_d} >= sigma5;
        d_minus_q = {i_d[ppf_pkg::DATA_W-1], i_d} - {i_cfg.q[ppf_pkg::DATA_W-1], i_cfg.q};
        p_minus_q = {i_cfg.p[ppf_pkg::DATA_W-1], i_cfg.p}
                  - {i_cfg.q[ppf_pkg::DATA_W-1], i_cfg.q};
    end

    always_comb begin
        n_side.sel   = ppf_pkg::SEL_FIXED;
        n_side.fixed = ppf_pkg::PREF_ZERO;
        n_num        = i_d;
        n_den        = {1'b0, i_cfg.sigma};
        unique case (i_cfg.shape)
            ppf_pkg::SHAPE_USUAL: begin
                n_side.fixed = le_zero ? ppf_pkg::PREF_ZERO : ppf_pkg::PREF_ONE;
            end
            ppf_pkg::SHAPE_U: begin
                n_side.fixed = le_q ? ppf_pkg::PREF_ZERO : ppf_pkg::PREF_ONE;
            end
            ppf_pkg::SHAPE_V: begin
                n_den = i_cfg.p;
                priority if (le_zero) n_side.fixed = ppf_pkg::PREF_ZERO;
                else if (le_p)        n_side.sel   = ppf_pkg::SEL_RAMP;
                else                  n_side.fixed = ppf_pkg::PREF_ONE;
            end
            ppf_pkg::SHAPE_LEVEL: begin
                priority if (le_q) n_side.fixed = ppf_pkg::PREF_ZERO;
                else if (le_p)     n_side.fixed = ppf_pkg::PREF_HALF;
                else               n_side.fixed = ppf_pkg::PREF_ONE;
            end
            ppf_pkg::SHAPE_V_IND: begin
                n_num = d_minus_q[ppf_pkg::DATA_W-1:0];
                n_den = p_minus_q[ppf_pkg::DATA_W-1:0];
                priority if (le_q) n_side.fixed = ppf_pkg::PREF_ZERO;
                else if (le_p)     n_side.sel   = ppf_pkg::SEL_RAMP;
                else               n_side.fixed = ppf_pkg::PREF_ONE;
            end
            ppf_pkg::SHAPE_GAUSS: begin
                // A zero spread falls into the saturated branch for any d above zero.
                priority if (le_zero) n_side.fixed = ppf_pkg::PREF_ZERO;
                else if (ge_5s)       n_side.fixed = ppf_pkg::PREF_ONE;
                else                  n_side.sel   = ppf_pkg::SEL_GAUSS;
            end
            default: begin
                n_side.fixed = ppf_pkg::PREF_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

[rtl/ppf_divider.sv]
// Pipelined restoring divider: one quotient bit per stage of (num * 2^16) / den.
// The quotient is known to stay below 2^19. Depends on ppf_pkg.
module ppf_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ppf_pkg::DATA_W-1:0]  i_num,
    input  logic [ppf_pkg::DATA_W-1:0]  i_den,
    input  ppf_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [ppf_pkg::QUO_W-1:0]   o_quo,
    output ppf_pkg::t_side              o_side
);

    localparam int QW = ppf_pkg::QUO_W;
    localparam int RW = ppf_pkg::REM_W;
    localparam int DW = ppf_pkg::DATA_W;

    logic          r_valid [QW];
    logic [RW-1:0] r_rem   [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [DW-1:0] r_num   [QW];
    logic [DW-1:0] r_den   [QW];
    ppf_pkg::t_side r_side [QW];

    logic [RW-1:0] n_rem [QW];
    logic [QW-1:0] n_quo [QW];

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            logic [RW-1:0] rem_in;
            logic [QW-1:0] quo_in;
            logic [DW-1:0] num_in;
            logic [DW-1:0] den_in;
            logic [RW-1:0] rem2;
            logic          dbit;
            int            k;
            k = QW - 1 - s;
            if (s == 0) begin
                rem_in = {4'b0000, i_num[DW-1:3]};
                quo_in = '0;
                num_in = i_num;
                den_in = i_den;
            end else begin
                rem_in = r_rem[s-1];
                quo_in = r_quo[s-1];
                num_in = r_num[s-1];
                den_in = r_den[s-1];
            end
            // Dividend bits 16 and up come from the low bits of num; the rest are zero.
            dbit = (k >= 16) ? num_in[k-16] : 1'b0;
            rem2 = {rem_in[RW-2:0], dbit};
            if (rem2 >= {1'b0, den_in}) begin
                n_rem[s] = rem2 - {1'b0, den_in};
                n_quo[s] = {quo_in[QW-2:0], 1'b1};
            end else begin
                n_rem[s] = rem2;
                n_quo[s] = {quo_in[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) r_valid[s] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < QW; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int s = 1; s < QW; s++) begin
                r_num[s]  <= r_num[s-1];
                r_den[s]  <= r_den[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[rtl/ppf_gauss.sv]
// Gaussian back end: squares the scaled difference and forms exp(-x) from three
// tables and a linear last step, one multiplier per stage. Depends on ppf_pkg.
module ppf_gauss (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ppf_pkg::QUO_W-1:0]   i_quo,
    input  ppf_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [ppf_pkg::E_W-1:0]     o_exp,
    output logic [ppf_pkg::PREF_W-1:0]  o_ramp,
    output ppf_pkg::t_side              o_side
);

    localparam int ST = 4;
    localparam int EW = ppf_pkg::E_W;
    localparam int PW = ppf_pkg::PREF_W;

    logic           r_valid [ST];
    ppf_pkg::t_side r_side  [ST];
    logic [PW-1:0]  r_ramp  [ST];

    logic [19:0]   r_x;
    logic [EW-1:0] r_e1, r_e2, r_e3;
    logic [3:0]    r_b1;
    logic [7:0]    r_t1, r_t2;

    logic [37:0]   n_sq;
    logic [49:0]   n_p1, n_p2, n_p3;
    logic [EW-1:0] n_lin;

    always_comb begin
        n_sq  = 38'(i_quo) * 38'(i_quo);
        n_p1  = 50'(ppf_pkg::en_lut(r_x[19:16])) * 50'(ppf_pkg::ea_lut(r_x[15:12]))
              + ppf_pkg::RND_Q24;
        n_p2  = 50'(r_e1) * 50'(ppf_pkg::eb_lut(r_b1)) + ppf_pkg::RND_Q24;
        n_lin = ppf_pkg::ONE_Q24 - {9'd0, r_t2, 8'd0};
        n_p3  = 50'(r_e2) * 50'(n_lin) + ppf_pkg::RND_Q24;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ST; s++) r_valid[s] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < ST; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_ramp[0] <= i_quo[PW-1:0];
            for (int s = 1; s < ST; s++) begin
                r_side[s] <= r_side[s-1];
                r_ramp[s] <= r_ramp[s-1];
            end
            // x = r^2 / 2^17 stays below 12.5 in Q.16.
            r_x  <= n_sq[36:17];
            r_e1 <= n_p1[24+EW-1:24];
            r_b1 <= r_x[11:8];
            r_t1 <= r_x[7:0];
            r_e2 <= n_p2[24+EW-1:24];
            r_t2 <= r_t1;
            r_e3 <= n_p3[24+EW-1:24];
        end
    end

    assign o_valid = r_valid[ST-1];
    assign o_exp   = r_e3;
    assign o_ramp  = r_ramp[ST-1];
    assign o_side  = r_side[ST-1];

endmodule

[rtl/promethee_preference_function_unit.sv]
// Preference function unit: maps one signed Q16.16 difference to a Q0.16 degree.
// From input transfer to output valid an item passes through one front stage,
// 19 divider stages (one quotient bit each), four gaussian stages, one output register.
// Throughput is one item per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// Depends on ppf_pkg, ppf_front, ppf_divider and ppf_gauss.
module promethee_preference_function_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] difference
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [16:0] preference, [23:17] zero
);

    ppf_pkg::t_cfg r_cfg;

    logic en;

    logic                         front_valid;
    logic [ppf_pkg::DATA_W-1:0]   front_num, front_den;
    ppf_pkg::t_side               front_side;

    logic                         div_valid;
    logic [ppf_pkg::QUO_W-1:0]    div_quo;
    ppf_pkg::t_side               div_side;

    logic                         g_valid;
    logic [ppf_pkg::E_W-1:0]      g_exp;
    logic [ppf_pkg::PREF_W-1:0]   g_ramp;
    ppf_pkg::t_side               g_side;

    logic                         r_out_valid;
    logic [ppf_pkg::PREF_W-1:0]   r_out_pref, n_out_pref;
    logic [ppf_pkg::E_W-1:0]      exp_rnd;

    // Config regs: written by the user only while the pipeline is empty, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape <= ppf_pkg::SHAPE_USUAL;
            r_cfg.q     <= '0;
            r_cfg.p     <= 32'd65536;
            r_cfg.sigma <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (ppf_pkg::t_reg_idx'(i_cfg_addr))
                ppf_pkg::REG_SHAPE: r_cfg.shape <= i_cfg_wdata[2:0];
                ppf_pkg::REG_Q:     r_cfg.q     <= i_cfg_wdata;
                ppf_pkg::REG_P:     r_cfg.p     <= i_cfg_wdata;
                ppf_pkg::REG_SIGMA: r_cfg.sigma <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Every stage advances together whenever the output register can take a
    // new item, so the input is ready in the same cycles.
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    ppf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_d     (i_s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (front_valid),
        .o_num   (front_num),
        .o_den   (front_den),
        .o_side  (front_side)
    );

    ppf_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_num   (front_num),
        .i_den   (front_den),
        .i_side  (front_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    ppf_gauss u_gauss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_quo   (div_quo),
        .i_side  (div_side),
        .o_valid (g_valid),
        .o_exp   (g_exp),
        .o_ramp  (g_ramp),
        .o_side  (g_side)
    );

    // Final select: fixed levels, the ramp quotient, or one minus the rounded
    // exponential brought from Q0.24 down to Q0.16.
    always_comb begin
        exp_rnd = (g_exp + 25'd128) >> 8;
        unique case (g_side.sel)
            ppf_pkg::SEL_RAMP:  n_out_pref = g_ramp;
            ppf_pkg::SEL_GAUSS: n_out_pref = ppf_pkg::PREF_ONE - exp_rnd[ppf_pkg::PREF_W-1:0];
            default:            n_out_pref = g_side.fixed;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pref <= n_out_pref;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_pref};

endmodule
